// ----- rtl/core/pfa_pkg.sv -----
package pfa_pkg;

  // Region geometry.
  localparam int PAGES      = 1024;
  localparam int PAGE_IDX_W = $clog2(PAGES);
  localparam int CNT_W      = PAGE_IDX_W + 1;
  localparam int PAGE_SHIFT = 12;
  localparam int OFF_W      = PAGE_IDX_W + PAGE_SHIFT;

  // Field widths of the stream items.
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 32;
  localparam int COUNT_W     = 11;
  localparam int STATUS_W    = 2;
  localparam int BASE_PAGE_W = 20;
  localparam int LIMIT_W     = 21;
  localparam int NEED_W      = SIZE_W - PAGE_SHIFT + 1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_SPACE  = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_INVALID   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_REGION_BASE_PAGE = 1'b0,
    CFG_SMALL_LIMIT      = 1'b1
  } cfg_index_t;

endpackage

// ----- rtl/core/page_run_first_fit_allocator_core.sv -----
// First-fit page allocator for a region of PAGES (1024) pages of 4 KiB each. An allocate
// transaction asks for a byte size; sizes at or below small_limit come back with status 3,
// larger sizes are rounded up to whole pages and the lowest free run that is long enough is
// marked used and its start address returned. A free transaction names the start address of
// a run that was handed out earlier and releases the whole run. Exactly one result
// transaction follows every input transaction. The block works on one item at a time: one
// page is visited per cycle by a small sequencer around a page bitmap and a run-length
// table, each with one write port and one read port. An allocate scans pages (up to PAGES)
// until a long enough run is found and then marks each page of the new run; a free looks up
// the run length and then releases each page of the run; a request rejected on its size or
// its address goes straight to its result, and a free whose page starts no run ends after
// the lookup. After reset the block sweeps both tables clear, one entry per cycle, and
// accepts no item until the sweep is done; configuration writes are taken at any time, and
// the result register lets the next item in while a result still waits to be taken.
module page_run_first_fit_allocator_core (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [pfa_pkg::LIMIT_W-1:0] cfg_data,
  // Request stream.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [63:0]                s_tdata,   // [31:0] size_bytes, [63:32] address
  input  logic                       s_tuser,   // [0] cmd
  // Result stream.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [47:0]                m_tdata    // [31:0] result_address, [33:32] status,
                                                // [44:34] page_count, [47:45] zero
);
  import pfa_pkg::*;

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_SCAN = 7'b0000100,
    ST_MARK = 7'b0001000,
    ST_LOOK = 7'b0010000,
    ST_REL  = 7'b0100000,
    ST_RESP = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [BASE_PAGE_W-1:0] region_base_page;
  logic [LIMIT_W-1:0]     small_limit;

  // Tables: one used bit per page and the run length recorded at each run's start page.
  logic             page_used   [PAGES];
  logic [CNT_W-1:0] run_len_tbl [PAGES];
  logic             used_q;
  logic [CNT_W-1:0] len_q;

  // Sequencer datapath.
  logic [PAGE_IDX_W-1:0] clr_ptr;
  logic [CNT_W-1:0]      scan_ptr;
  logic                  rd_pend;
  logic [CNT_W-1:0]      run;
  logic [CNT_W-1:0]      need;
  logic [PAGE_IDX_W-1:0] mark_ptr;
  logic [PAGE_IDX_W-1:0] mark_end;
  logic [PAGE_IDX_W-1:0] free_idx;
  logic [PAGE_IDX_W-1:0] rel_ptr;
  logic [CNT_W-1:0]      rel_cnt;
  logic [CNT_W-1:0]      rel_len;

  // Pending result, held until the output register is free.
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;
  logic [CNT_W-1:0]  res_count;

  // Request fields and request decode.
  logic [SIZE_W-1:0]     in_size;
  logic [ADDR_W-1:0]     in_addr;
  cmd_t                  in_cmd;
  logic [ADDR_W-1:0]     base_addr;
  logic [ADDR_W-1:0]     free_off;
  logic [PAGE_IDX_W-1:0] in_idx;
  logic [NEED_W-1:0]     size_pages;

  // Scan step.
  logic [CNT_W-1:0]      chk_idx;
  logic [CNT_W-1:0]      run_inc;
  logic [CNT_W-1:0]      start_full;
  logic [PAGE_IDX_W-1:0] start_idx;

  // Table write and read ports.
  logic                  used_we;
  logic [PAGE_IDX_W-1:0] used_wa;
  logic                  used_wd;
  logic [PAGE_IDX_W-1:0] used_ra;
  logic                  len_we;
  logic [PAGE_IDX_W-1:0] len_wa;
  logic [CNT_W-1:0]      len_wd;
  logic [PAGE_IDX_W-1:0] len_ra;

  assign in_size = s_tdata[SIZE_W-1:0];
  assign in_addr = s_tdata[63:SIZE_W];
  assign in_cmd  = cmd_t'(s_tuser);

  assign base_addr  = {region_base_page, {PAGE_SHIFT{1'b0}}};
  assign free_off   = in_addr - base_addr;
  assign in_idx     = free_off[OFF_W-1:PAGE_SHIFT];
  // Whole pages needed, rounded up.
  assign size_pages = {1'b0, in_size[SIZE_W-1:PAGE_SHIFT]}
                    + NEED_W'(in_size[PAGE_SHIFT-1:0] != '0);

  // The bit in used_q belongs to the page just below scan_ptr.
  assign chk_idx    = scan_ptr - CNT_W'(1);
  assign run_inc    = used_q ? '0 : run + CNT_W'(1);
  assign start_full = scan_ptr - run_inc;
  assign start_idx  = start_full[PAGE_IDX_W-1:0];

  assign used_ra = scan_ptr[PAGE_IDX_W-1:0];
  assign len_ra  = in_idx;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    used_we = 1'b0;
    used_wa = '0;
    used_wd = 1'b0;
    len_we  = 1'b0;
    len_wa  = '0;
    len_wd  = '0;
    unique case (state)
      ST_CLR: begin
        used_we = 1'b1;
        used_wa = clr_ptr;
        len_we  = 1'b1;
        len_wa  = clr_ptr;
      end
      ST_SCAN: begin
        // The run length is recorded in the cycle the fitting run is found.
        if (rd_pend && run_inc == need) begin
          len_we = 1'b1;
          len_wa = start_idx;
          len_wd = need;
        end
      end
      ST_MARK: begin
        used_we = 1'b1;
        used_wa = mark_ptr;
        used_wd = 1'b1;
      end
      ST_LOOK: begin
        if (len_q != '0) begin
          len_we = 1'b1;
          len_wa = free_idx;
        end
      end
      ST_REL: begin
        used_we = 1'b1;
        used_wa = rel_ptr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      page_used[used_wa] <= used_wd;
    end
    used_q <= page_used[used_ra];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      run_len_tbl[len_wa] <= len_wd;
    end
    len_q <= run_len_tbl[len_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLR;
      clr_ptr          <= '0;
      m_tvalid         <= 1'b0;
      region_base_page <= '0;
      small_limit      <= LIMIT_W'(2048);
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_REGION_BASE_PAGE: region_base_page <= cfg_data[BASE_PAGE_W-1:0];
          CFG_SMALL_LIMIT:      small_limit      <= cfg_data;
          default: begin
          end
        endcase
      end

      // In ST_RESP the output register is reloaded below instead.
      if (m_tvalid && m_tready && state != ST_RESP) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLR: begin
          clr_ptr <= clr_ptr + PAGE_IDX_W'(1);
          if (clr_ptr == PAGE_IDX_W'(PAGES - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_tvalid) begin
            res_addr  <= '0;
            res_count <= '0;
            if (in_cmd == CMD_FREE) begin
              if (free_off[ADDR_W-1:OFF_W] != '0) begin
                res_status <= STATUS_INVALID;
                state      <= ST_RESP;
              end else if (free_off[PAGE_SHIFT-1:0] != '0) begin
                res_status <= STATUS_NOT_FOUND;
                state      <= ST_RESP;
              end else begin
                free_idx <= in_idx;
                state    <= ST_LOOK;
              end
            end else begin
              if (in_size <= SIZE_W'(small_limit)) begin
                res_status <= STATUS_INVALID;
                state      <= ST_RESP;
              end else if (size_pages > NEED_W'(PAGES)) begin
                res_status <= STATUS_NO_SPACE;
                state      <= ST_RESP;
              end else begin
                need     <= size_pages[CNT_W-1:0];
                scan_ptr <= '0;
                rd_pend  <= 1'b0;
                run      <= '0;
                state    <= ST_SCAN;
              end
            end
          end
        end

        ST_SCAN: begin
          // Issue the next page read while checking the previous one.
          if (scan_ptr != CNT_W'(PAGES)) begin
            scan_ptr <= scan_ptr + CNT_W'(1);
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            run <= run_inc;
            if (run_inc == need) begin
              mark_ptr   <= start_idx;
              mark_end   <= chk_idx[PAGE_IDX_W-1:0];
              res_addr   <= base_addr + (ADDR_W'(start_idx) << PAGE_SHIFT);
              res_status <= STATUS_OK;
              res_count  <= need;
              state      <= ST_MARK;
            end else if (chk_idx == CNT_W'(PAGES - 1)) begin
              res_status <= STATUS_NO_SPACE;
              state      <= ST_RESP;
            end
          end
        end

        ST_MARK: begin
          mark_ptr <= mark_ptr + PAGE_IDX_W'(1);
          if (mark_ptr == mark_end) begin
            state <= ST_RESP;
          end
        end

        ST_LOOK: begin
          if (len_q == '0) begin
            res_status <= STATUS_NOT_FOUND;
            state      <= ST_RESP;
          end else begin
            rel_ptr    <= free_idx;
            rel_cnt    <= CNT_W'(1);
            rel_len    <= len_q;
            res_status <= STATUS_OK;
            res_count  <= len_q;
            state      <= ST_REL;
          end
        end

        ST_REL: begin
          rel_ptr <= rel_ptr + PAGE_IDX_W'(1);
          rel_cnt <= rel_cnt + CNT_W'(1);
          if (rel_cnt == rel_len || rel_ptr == PAGE_IDX_W'(PAGES - 1)) begin
            state <= ST_RESP;
          end
        end

        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {3'b000, COUNT_W'(res_count), res_status, res_addr};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A scan never holds a run as long as the request: that would already have ended it.
  a_scan_run_below_need: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (run < need && need != '0))
    else $error("scan run counter reached the requested length");

  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK) |-> (mark_ptr <= mark_end))
    else $error("marking pointer passed the end of the run");

  a_release_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REL) |-> (rel_len != '0 && rel_cnt <= rel_len))
    else $error("release counter passed the recorded run length");

  a_ok_has_pages: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && res_status == STATUS_OK) |-> (res_count != '0))
    else $error("successful result carries no pages");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state lost its one-hot code");

endmodule

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfa_pkg::*;

  // A stretch this long with no transaction on any channel means the block has hung.
  // The slowest item scans and then marks the whole region, and the clearing sweep after
  // reset visits every page once. Receiver stalls come on top of that.
  localparam int QUIET_LIMIT = 20000;

  // How a free request gets its address. Most frees aim at a run that is live when the
  // request reaches the bus, so that address is chosen only at that point.
  typedef enum logic [1:0] {
    FREE_AT_ADDRESS,
    FREE_LIVE_RUN,
    FREE_LIVE_SKEWED
  } free_target_t;

  typedef struct {
    cmd_t              cmd;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    free_target_t      target;
    bit                drain;   // hold this request back until no result is outstanding
  } page_req_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } page_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = CFG_REGION_BASE_PAGE;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;   // [31:0] size_bytes, [63:32] address
  logic                 s_tuser = 1'b0; // [0] cmd
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [47:0]          m_tdata;        // [31:0] result_address, [33:32] status,
                                        // [44:34] page_count, [47:45] zero

  page_run_first_fit_allocator_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the allocator: the page bitmap, the run length recorded at each run's
  // start page, and the two configuration registers at their reset values.
  bit                 page_busy [PAGES];
  bit [COUNT_W-1:0]   run_at_start [PAGES];
  bit [BASE_PAGE_W-1:0] shadow_base_page = '0;
  bit [LIMIT_W-1:0]     shadow_small_limit = 21'd2048;

  page_req_t    pending_reqs [$];
  page_result_t expected_results [$];
  page_req_t    req_on_bus;
  int           n_requests_taken = 0;
  int           n_results_taken = 0;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles = 0;

  // Applies one accepted request to the shadow state and returns the result it must cause.
  function automatic page_result_t apply_page_request(input page_req_t req);
    page_result_t      res;
    logic [SIZE_W:0]   pages_needed;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] offset;
    int                run_len;
    int                first;
    int                idx;
    bit                found;
    res.addr   = '0;
    res.status = STATUS_OK;
    res.count  = '0;
    base_addr  = {shadow_base_page, 12'h000};
    if (req.cmd == CMD_ALLOC) begin
      if (req.size <= shadow_small_limit) begin
        res.status = STATUS_INVALID;
      end else begin
        pages_needed = ({1'b0, req.size} + 33'd4095) >> PAGE_SHIFT;
        res.status = STATUS_NO_SPACE;
        if (pages_needed <= PAGES) begin
          // First fit: the run ends at the first page where enough free pages in a row
          // have been seen.
          run_len = 0;
          found = 1'b0;
          for (int i = 0; i < PAGES && !found; i++) begin
            run_len = page_busy[i] ? 0 : run_len + 1;
            if (run_len == pages_needed) begin
              found = 1'b1;
              first = i + 1 - run_len;
              for (int k = first; k <= i; k++) page_busy[k] = 1'b1;
              run_at_start[first] = COUNT_W'(run_len);
              res.addr   = base_addr + (first << PAGE_SHIFT);
              res.status = STATUS_OK;
              res.count  = COUNT_W'(run_len);
            end
          end
        end
      end
    end else begin
      // The region may wrap past the top of the address space, so the offset is taken
      // modulo 2^32.
      offset = req.addr - base_addr;
      if (offset >= PAGES * 4096) begin
        res.status = STATUS_INVALID;
      end else begin
        idx = int'(offset >> PAGE_SHIFT);
        if (offset[PAGE_SHIFT-1:0] != 0 || run_at_start[idx] == 0) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          run_len = int'(run_at_start[idx]);
          for (int k = 0; k < run_len && idx + k < PAGES; k++) page_busy[idx + k] = 1'b0;
          run_at_start[idx] = '0;
          res.count = COUNT_W'(run_len);
        end
      end
    end
    return res;
  endfunction

  // Chooses the address of a free request just before it goes on the bus. A skewed pick
  // lands inside a live run: either off a page boundary or on a later page of a long run.
  function automatic logic [ADDR_W-1:0] pick_free_address(input page_req_t req);
    int                starts [$];
    int                pick;
    int                len;
    logic [ADDR_W-1:0] a;
    if (req.target == FREE_AT_ADDRESS) return req.addr;
    for (int i = 0; i < PAGES; i++) begin
      if (run_at_start[i] != 0) starts.push_back(i);
    end
    if (starts.size() == 0) return req.addr;
    pick = starts[$urandom_range(0, starts.size() - 1)];
    len  = int'(run_at_start[pick]);
    a    = {shadow_base_page, 12'h000} + (pick << PAGE_SHIFT);
    if (req.target == FREE_LIVE_SKEWED) begin
      if (len > 1 && $urandom_range(0, 1) == 1) a = a + ($urandom_range(1, len - 1) << PAGE_SHIFT);
      else a = a + $urandom_range(1, 4095);
    end
    return a;
  endfunction

  function automatic page_req_t alloc_req(input logic [SIZE_W-1:0] size);
    page_req_t req;
    req.cmd    = CMD_ALLOC;
    req.size   = size;
    req.addr   = '0;
    req.target = FREE_AT_ADDRESS;
    req.drain  = 1'b0;
    return req;
  endfunction

  function automatic page_req_t free_req(input logic [ADDR_W-1:0] addr);
    page_req_t req;
    req.cmd    = CMD_FREE;
    req.size   = '0;
    req.addr   = addr;
    req.target = FREE_AT_ADDRESS;
    req.drain  = 1'b0;
    return req;
  endfunction

  // Random traffic for one phase. Allocations are mostly a few pages with random byte
  // sizes, lifted above the small-size limit; frees mostly hit live runs. The rest are
  // boundary sizes, misaligned or interior frees, and stray addresses.
  function automatic page_req_t random_request(input logic [BASE_PAGE_W-1:0] base,
                                               input logic [LIMIT_W-1:0] limit,
                                               input bit drain);
    page_req_t req;
    int        pick;
    int        pages;
    pick       = $urandom_range(0, 99);
    req.drain  = drain;
    req.target = FREE_AT_ADDRESS;
    if (pick < 47) begin
      req.cmd  = CMD_ALLOC;
      req.addr = $urandom();
      if (pick < 40) begin
        pages = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PAGES) : $urandom_range(1, 12);
        req.size = (pages - 1) * 4096 + $urandom_range(1, 4096);
        if (req.size <= limit) req.size = limit + $urandom_range(1, 4096);
      end else begin
        case ($urandom_range(0, 5))
          0: req.size = '0;
          1: req.size = limit;
          2: req.size = limit + 1;
          3: req.size = '1;
          4: req.size = PAGES * 4096 + $urandom_range(0, 1);
          default: req.size = $urandom();
        endcase
      end
    end else begin
      req.cmd  = CMD_FREE;
      req.size = $urandom();
      // Page-aligned address somewhere in the region; also the fallback for a live pick
      // when no run is live.
      req.addr = {base, 12'h000} + ($urandom_range(0, PAGES - 1) << PAGE_SHIFT);
      if (pick < 82) req.target = FREE_LIVE_RUN;
      else if (pick < 88) req.target = FREE_LIVE_SKEWED;
      else if (pick >= 94) req.addr = $urandom();
    end
    return req;
  endfunction

  // Request driver. A request is predicted at the edge where its transaction completes,
  // and the next one is chosen at the same edge, so the shadow state is always current
  // when a live run is picked.
  always @(posedge clk) begin : drive_requests
    bit took;
    bit load;
    int outstanding;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      took = s_tvalid && s_tready;
      if (took) begin
        expected_results.push_back(apply_page_request(req_on_bus));
        n_requests_taken <= n_requests_taken + 1;
      end
      if (!s_tvalid || s_tready) begin
        load = pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
        outstanding = n_requests_taken + (took ? 1 : 0) - n_results_taken;
        if (load && pending_reqs[0].drain && outstanding != 0) load = 1'b0;
        if (load) begin
          req_on_bus = pending_reqs.pop_front();
          if (req_on_bus.cmd == CMD_FREE) req_on_bus.addr = pick_free_address(req_on_bus);
          s_tdata <= {req_on_bus.addr, req_on_bus.size};
          s_tuser <= req_on_bus.cmd;
        end
        s_tvalid <= load;
      end
    end
  end

  // Result monitor. Whether an expectation is waiting is judged from the two transaction
  // counters, which only change through nonblocking updates, so the verdict does not hang
  // on the order in which the two blocks run at an edge.
  always @(posedge clk) begin : check_results
    page_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (n_results_taken == n_requests_taken) begin
          mismatches++;
          $display("%0t: result with no request outstanding: %h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          n_results_taken <= n_results_taken + 1;
          if (m_tdata[31:0] !== want.addr) begin
            mismatches++;
            $display("%0t: result_address expected %h actual %h", $time, want.addr,
                     m_tdata[31:0]);
          end
          if (m_tdata[33:32] !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_tdata[33:32]);
          end
          if (m_tdata[44:34] !== want.count) begin
            mismatches++;
            $display("%0t: page_count expected %0d actual %0d", $time, want.count,
                     m_tdata[44:34]);
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register writes are issued only while no request is in flight, so the shadow copy can
  // take the new value at the edge of the write transaction.
  task automatic write_register(input cfg_index_t idx, input logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_REGION_BASE_PAGE) shadow_base_page = value[BASE_PAGE_W-1:0];
    else shadow_small_limit = value;
  endtask

  task automatic wait_until_settled();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || n_results_taken != n_requests_taken);
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input logic [BASE_PAGE_W-1:0] base,
                                  input logic [LIMIT_W-1:0] limit, input int n_items);
    write_register(CFG_REGION_BASE_PAGE, {1'b0, base});
    write_register(CFG_SMALL_LIMIT, limit);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    // Halfway through, the sender holds off until every result so far has come back.
    for (int i = 0; i < n_items; i++) begin
      pending_reqs.push_back(random_request(base, limit, i == n_items / 2));
    end
    wait_until_settled();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset configuration: base page 0, small limit 2048. The block
    // sits in its clearing sweep first, so these simply wait for s_tready.
    @(negedge clk);
    pending_reqs.push_back(alloc_req(32'd0));              // zero size is small
    pending_reqs.push_back(alloc_req(32'd2048));           // exactly the small limit
    pending_reqs.push_back(alloc_req(32'd2049));           // one page, page 0
    pending_reqs.push_back(alloc_req(32'd4096));           // page 1
    pending_reqs.push_back(alloc_req(32'd4097));           // rounds up to pages 2..3
    pending_reqs.push_back(alloc_req(32'hFFFF_FFFF));      // largest size, no space
    pending_reqs.push_back(alloc_req(PAGES * 4096 + 1));   // one page more than the region
    pending_reqs.push_back(free_req(32'h0000_1000));       // release page 1
    pending_reqs.push_back(free_req(32'h0000_1000));       // second free finds no run
    pending_reqs.push_back(free_req(32'h0000_2001));       // misaligned
    pending_reqs.push_back(free_req(PAGES * 4096));        // first address past the region
    pending_reqs.push_back(free_req(32'hFFFF_FFFF));       // far outside the region
    pending_reqs.push_back(alloc_req(32'd4096));           // reuses the hole at page 1
    pending_reqs.push_back(alloc_req(3 * 4096));           // pages 4..6
    pending_reqs.push_back(free_req(32'h0000_0000));
    pending_reqs.push_back(free_req(32'h0000_2000));
    pending_reqs.push_back(alloc_req(1017 * 4096));        // fills pages 7..1023
    pending_reqs.push_back(alloc_req(32'd4096));           // page 0
    pending_reqs.push_back(alloc_req(3 * 4096));           // only two free pages left
    pending_reqs.push_back(free_req(32'h0000_7000));
    pending_reqs.push_back(free_req(32'h0000_1000));
    pending_reqs.push_back(free_req(32'h0000_4000));
    pending_reqs.push_back(free_req(32'h0000_0000));
    pending_reqs.push_back(alloc_req(PAGES * 4096));       // the whole region in one run
    pending_reqs.push_back(free_req(32'h0000_0000));
    wait_until_settled();

    // Random phases, each with its own handshake pressure and configuration. The highest
    // base page makes the region wrap past the top of the address space.
    run_random_phase(84, 0, 20'hFFFFF, 21'd0, 145);
    run_random_phase(0, 84, BASE_PAGE_W'($urandom_range(0, 20'hFFFFF)), 21'd1048576, 140);
    run_random_phase(27, 27, 20'h00000, LIMIT_W'($urandom_range(2049, 1048575)), 140);
    run_random_phase(0, 0, BASE_PAGE_W'($urandom_range(0, 20'hFFFFF)), 21'd2048, 130);

    repeat (16) @(posedge clk);
    if (mismatches == 0 && n_results_taken == n_requests_taken) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- page_run_first_fit_allocator_core.f -----
rtl/core/pfa_pkg.sv
rtl/core/page_run_first_fit_allocator_core.sv
verif/tb.sv
